// ----- design/rate_limited_change_list_macros.svh -----
// Assertion macros for the change list RTL.
`ifndef RATE_LIMITED_CHANGE_LIST_MACROS_SVH
`define RATE_LIMITED_CHANGE_LIST_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RLCL_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define RLCL_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/rlcl_pkg.sv -----
// Shared constants for the rate limited change list.
`timescale 1ns / 1ps
`default_nettype none
package rlcl_pkg;
   localparam int DefObjectCount = 32;
   localparam logic [15:0] WaitDefault = 16'd100;

   localparam logic [1:0] OP_MARK   = 2'd0;
   localparam logic [1:0] OP_SCAN   = 2'd1;
   localparam logic [1:0] OP_PERIOD = 2'd2;

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_WAIT = 1'b1;
endpackage
`default_nettype wire

// ----- design/rate_limited_change_list.sv -----
// Top level of the rate limited change list.
//
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | operation, index, period, tick
//  rsp     | out       | rsp_valid/rsp_stall | kind, index, wait, last flag
//  csr     | in        | csr_valid/csr_ready | max_wait
//
// A scan latches its tick, then steps through each listed object in turn
// (the queue of cells rotates once through its head cell) and ends with
// the wait report. req_stall is high for the whole scan; a due object
// waits for a free output register. Synchronous reset clears the list,
// flags, periods and stamps.
`timescale 1ns / 1ps
`default_nettype none
`include "rate_limited_change_list_macros.svh"
module rate_limited_change_list import rlcl_pkg::*; #(
   parameter int OBJECT_COUNT = DefObjectCount
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [4:0]  req_object_index,
   input  wire logic [15:0] req_period_value,
   input  wire logic [31:0] req_now_tick,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic [4:0]       rsp_sent_index,
   output logic [15:0]      rsp_wait_ticks,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_wait
);
   localparam int IW = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
   localparam int CW = $clog2(OBJECT_COUNT + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           steps_ff, steps_in;
   logic [31:0]             now_ff, now_in;
   logic [15:0]             wait_ff, wait_in;
   logic [15:0]             max_wait_ff;
   logic [OBJECT_COUNT-1:0] flags_ff;
   logic [15:0]             period_ff [OBJECT_COUNT];
   logic [31:0]             stamp_ff  [OBJECT_COUNT];

   logic             rsp_valid_ff, kind_ff, last_ff;
   logic [4:0]       idx_ff;
   logic [15:0]      wait_out_ff;

   logic [IW-1:0]    cell_q [OBJECT_COUNT];
   logic [6:0]       req_idx_wide;
   logic [IW-1:0]    req_idx;
   logic             req_in_range;
   logic             accept;
   logic             append;
   logic             slot_free;
   logic [IW-1:0]    head;
   logic [6:0]       head_wide;
   logic [31:0]      elapsed;
   logic [31:0]      period_wide;
   logic             due;
   logic [15:0]      remaining;
   logic             step;
   logic             keep;
   logic             cell_load;
   logic [CW-1:0]    tail_pos;
   logic             put_send, put_wait;

   // handshakes
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign req_idx_wide = 7'(req_object_index);
   assign req_idx      = req_idx_wide[IW-1:0];
   assign req_in_range = (req_idx_wide < 7'(OBJECT_COUNT));
   assign append = accept && (req_operation == OP_MARK) && req_in_range
                   && !flags_ff[req_idx];

   // head object timing
   assign head        = cell_q[0];
   assign head_wide   = 7'(head);
   assign elapsed     = now_ff - stamp_ff[head];
   assign period_wide = 32'(period_ff[head]);
   assign due         = (period_ff[head] == 16'd0) || (elapsed > period_wide);
   assign remaining   = 16'(period_wide - elapsed);
   assign step        = (state_ff == ST_SCAN) && (!due || slot_free);
   assign keep        = step && !due;
   assign put_send    = step && due;
   assign put_wait    = (state_ff == ST_REPORT) && slot_free;

   assign cell_load = append || keep;
   assign tail_pos  = append ? count_ff : (count_ff - CW'(1));

   // queue of cells
   for (genvar i = 0; i < OBJECT_COUNT; i++) begin : g_cell
      logic [IW-1:0] next_d;
      if (i == OBJECT_COUNT - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid
         assign next_d = cell_q[i+1];
      end
      rlcl_cell #(.IW(IW), .CW(CW), .POS(i)) u_cell (
         .clock     (clock),
         .shift_en  (step),
         .load_en   (cell_load),
         .tail_pos  (tail_pos),
         .load_data (append ? req_idx : head),
         .next_data (next_d),
         .data      (cell_q[i])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      steps_in = steps_ff;
      now_in   = now_ff;
      wait_in  = wait_ff;
      if (append) begin
         count_in = count_ff + CW'(1);
      end
      if (accept && (req_operation == OP_SCAN)) begin
         now_in   = req_now_tick;
         steps_in = count_ff;
         wait_in  = max_wait_ff;
         state_in = (count_ff == '0) ? ST_REPORT : ST_SCAN;
      end
      if (step) begin
         steps_in = steps_ff - CW'(1);
         if (due) begin
            count_in = count_ff - CW'(1);
         end else if (remaining < wait_ff) begin
            wait_in = remaining;
         end
         if (steps_ff == CW'(1)) begin
            state_in = ST_REPORT;
         end
      end
      if (put_wait) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         max_wait_ff <= WaitDefault;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            max_wait_ff <= csr_max_wait;
         end
      end
      steps_ff <= steps_in;
      now_ff   <= now_in;
      wait_ff  <= wait_in;
   end

   // per-object flags, periods and stamps
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         for (int i = 0; i < OBJECT_COUNT; i++) begin
            period_ff[i] <= '0;
            stamp_ff[i]  <= '0;
         end
      end else begin
         if (append) begin
            flags_ff[req_idx] <= 1'b1;
         end
         if (accept && (req_operation == OP_PERIOD) && req_in_range) begin
            period_ff[req_idx] <= req_period_value;
         end
         if (put_send) begin
            flags_ff[head] <= 1'b0;
            stamp_ff[head] <= now_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (put_send || put_wait) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (put_send) begin
         kind_ff     <= KIND_SEND;
         idx_ff      <= head_wide[4:0];
         wait_out_ff <= 16'd0;
         last_ff     <= 1'b0;
      end else if (put_wait) begin
         kind_ff     <= KIND_WAIT;
         idx_ff      <= 5'd0;
         wait_out_ff <= wait_ff;
         last_ff     <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_sent_index  = idx_ff;
   assign rsp_wait_ticks  = wait_out_ff;
   assign rsp_last_of_run = last_ff;

   // checks
   `RLCL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(OBJECT_COUNT), "list count overflow")
   `RLCL_ASSERT_NOW(a_count_flags, state_ff == ST_IDLE,
      $countones(flags_ff) == 32'(count_ff), "list count disagrees with flags")
   `RLCL_ASSERT_NEXT(a_send_clears, put_send, !flags_ff[$past(head)], "sent object still flagged")
endmodule
`default_nettype wire

// ----- design/rlcl_cell.sv -----
// One cell of the list queue: holds one object index, shifts towards the head.
`timescale 1ns / 1ps
`default_nettype none
module rlcl_cell import rlcl_pkg::*; #(
   parameter int IW  = 5,
   parameter int CW  = 6,
   parameter int POS = 0
) (
   input  wire logic          clock,
   input  wire logic          shift_en,
   input  wire logic          load_en,
   input  wire logic [CW-1:0] tail_pos,
   input  wire logic [IW-1:0] load_data,
   input  wire logic [IW-1:0] next_data,
   output logic      [IW-1:0] data
);
   logic [IW-1:0] data_ff;
   logic [IW-1:0] data_in;

   // loading at the tail wins over the shift
   always_comb begin
      data_in = data_ff;
      if (load_en && (tail_pos == CW'(POS))) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule
`default_nettype wire

// ----- sim/tb_rate_limited_change_list.sv -----
// Self-checking testbench for the rate limited change list.
`timescale 1ns / 1ps
module tb_rate_limited_change_list;
   import rlcl_pkg::*;

   localparam int NOBJ = 32;
   localparam logic [5:0] NO_OBJ = 6'd63;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        kind;
      logic [4:0]  index;
      logic [15:0] wait_t;
      logic        last;
   } send_word_t;

   typedef struct {
      logic [1:0]  op;
      logic [4:0]  index;
      logic [15:0] period;
      logic [31:0] tick;
      logic        has_exp;
      send_word_t  exp_word;
   } dir_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [4:0]  req_object_index = '0;
   logic [15:0] req_period_value = '0;
   logic [31:0] req_now_tick = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [4:0]  rsp_sent_index;
   logic [15:0] rsp_wait_ticks;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_wait = '0;

   rate_limited_change_list dut (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_object_index,
      .req_period_value, .req_now_tick, .rsp_valid, .rsp_stall, .rsp_result_kind,
      .rsp_sent_index, .rsp_wait_ticks, .rsp_last_of_run, .csr_valid, .csr_ready,
      .csr_max_wait
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state
   logic        pr_listed [NOBJ];
   logic [5:0]  pr_link [NOBJ];
   logic [15:0] pr_period [NOBJ];
   logic [31:0] pr_stamp [NOBJ];
   logic [5:0]  pr_head, pr_tail;
   logic [15:0] pr_max_wait;

   send_word_t  pending_words[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          stall_mode = 0;   // 0 random, 1 long hold-off

   // Work out the words one request word causes.
   task automatic predict_word(input logic [1:0] op, input logic [4:0] idx,
                               input logic [15:0] per, input logic [31:0] now);
      logic [5:0]  cur, prev, nxt;
      logic [31:0] elapsed, wt;
      int          visited;
      send_word_t  w;
      if (op == OP_MARK) begin
         if (!pr_listed[idx]) begin
            pr_link[idx] = NO_OBJ;
            pr_listed[idx] = 1'b1;
            if (pr_tail >= NOBJ) pr_head = {1'b0, idx};
            else pr_link[pr_tail] = {1'b0, idx};
            pr_tail = {1'b0, idx};
         end
      end else if (op == OP_PERIOD) begin
         pr_period[idx] = per;
      end else if (op == OP_SCAN) begin
         cur = pr_head;
         prev = NO_OBJ;
         wt = pr_max_wait;
         visited = 0;
         while (cur < NOBJ && visited < NOBJ) begin
            nxt = pr_link[cur];
            elapsed = now - pr_stamp[cur];
            visited++;
            if (pr_period[cur] == 0 || elapsed > pr_period[cur]) begin
               w.kind = KIND_SEND; w.index = cur[4:0]; w.wait_t = '0; w.last = 1'b0;
               pending_words.push_back(w);
               pr_stamp[cur] = now;
               if (prev >= NOBJ) pr_head = nxt;
               else pr_link[prev] = nxt;
               if (pr_tail == cur) pr_tail = prev;
               pr_link[cur] = NO_OBJ;
               pr_listed[cur] = 1'b0;
            end else begin
               if (pr_period[cur] - elapsed < wt) wt = pr_period[cur] - elapsed;
               prev = cur;
            end
            cur = nxt;
         end
         w.kind = KIND_WAIT; w.index = '0; w.wait_t = wt[15:0]; w.last = 1'b1;
         pending_words.push_back(w);
      end
   endtask

   // Send one request word; waits for acceptance.
   task automatic send_req(input logic [1:0] op, input logic [4:0] idx,
                           input logic [15:0] per, input logic [31:0] now);
      req_valid <= 1'b1;
      req_operation <= op;
      req_object_index <= idx;
      req_period_value <= per;
      req_now_tick <= now;
      do @(posedge clock); while (req_stall);
      predict_word(op, idx, per, now);
      @(negedge clock);
   endtask

   task automatic req_gap();
      int n;
      if ($urandom_range(0, 9) < 6) n = 0;
      else if ($urandom_range(0, 9) < 9) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Drain, settle, then write max_wait.
   task automatic write_max_wait(input logic [15:0] v);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_wait <= v;
      do @(posedge clock); while (!csr_ready);
      pr_max_wait = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver stall pattern
   always @(negedge clock) begin
      if (stall_mode == 1) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 9) < 3) rsp_stall <= 1'b1;
      else rsp_stall <= 1'b0;
   end

   // Result checking at the rising edge
   always @(posedge clock) begin
      send_word_t got, want;
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_result_kind; got.index = rsp_sent_index;
         got.wait_t = rsp_wait_ticks; got.last = rsp_last_of_run;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   dir_row_t dir_rows [20];
   logic [31:0] tick_now;

   initial begin
      int k;
      logic [1:0] op;
      for (int i = 0; i < NOBJ; i++) begin
         pr_listed[i] = 1'b0; pr_link[i] = NO_OBJ; pr_period[i] = '0; pr_stamp[i] = '0;
      end
      pr_head = NO_OBJ; pr_tail = NO_OBJ; pr_max_wait = WaitDefault;

      // Directed table: empty scan, extremes, ignored op, equal elapsed
      dir_rows[0]  = '{OP_SCAN, 5'd0, 16'd0, 32'd0, 1'b1, '{KIND_WAIT, 5'd0, WaitDefault, 1'b1}};
      dir_rows[1]  = '{OP_MARK, 5'd0, 16'd0, 32'd0, 1'b0, '0};
      dir_rows[2]  = '{OP_SCAN, 5'd0, 16'd0, 32'd5, 1'b0, '0};
      dir_rows[3]  = '{OP_PERIOD, 5'd31, 16'hffff, 32'd0, 1'b0, '0};
      dir_rows[4]  = '{OP_PERIOD, 5'd3, 16'd10, 32'd0, 1'b0, '0};
      dir_rows[5]  = '{OP_MARK, 5'd31, 16'd0, 32'd0, 1'b0, '0};
      dir_rows[6]  = '{OP_MARK, 5'd3, 16'd0, 32'd0, 1'b0, '0};
      dir_rows[7]  = '{OP_MARK, 5'd3, 16'hffff, 32'hffffffff, 1'b0, '0};
      dir_rows[8]  = '{2'd3, 5'd7, 16'h1234, 32'h1, 1'b0, '0};
      dir_rows[9]  = '{OP_SCAN, 5'd0, 16'd0, 32'd10, 1'b0, '0};
      dir_rows[10] = '{OP_SCAN, 5'd0, 16'd0, 32'd11, 1'b0, '0};
      dir_rows[11] = '{OP_SCAN, 5'd0, 16'd0, 32'hffffffff, 1'b0, '0};
      dir_rows[12] = '{OP_MARK, 5'd1, 16'd0, 32'd0, 1'b0, '0};
      dir_rows[13] = '{OP_MARK, 5'd2, 16'd0, 32'd0, 1'b0, '0};
      dir_rows[14] = '{OP_PERIOD, 5'd2, 16'd1, 32'd0, 1'b0, '0};
      dir_rows[15] = '{OP_SCAN, 5'd0, 16'd0, 32'hffffffff, 1'b0, '0};
      dir_rows[16] = '{OP_SCAN, 5'd0, 16'd0, 32'h00000000, 1'b0, '0};
      dir_rows[17] = '{OP_SCAN, 5'd0, 16'd0, 32'h00000001, 1'b0, '0};
      dir_rows[18] = '{OP_PERIOD, 5'd0, 16'd0, 32'd0, 1'b0, '0};
      dir_rows[19] = '{OP_SCAN, 5'd0, 16'd0, 32'h80000000, 1'b0, '0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].has_exp) begin
            // typed-in result must agree with the predictor too
            send_req(dir_rows[i].op, dir_rows[i].index, dir_rows[i].period,
                     dir_rows[i].tick);
            if (pending_words[pending_words.size()-1] !== dir_rows[i].exp_word) begin
               mismatches++;
               $display("table row %0d disagrees with prediction", i);
            end
         end else
            send_req(dir_rows[i].op, dir_rows[i].index, dir_rows[i].period,
                     dir_rows[i].tick);
      end

      // Random phases over several max_wait settings
      tick_now = $urandom;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_max_wait(16'd0);
            1: write_max_wait(16'hffff);
            2: write_max_wait(16'd1);
            3: write_max_wait(16'($urandom_range(2, 200)));
            default: write_max_wait(WaitDefault);
         endcase
         if (ph == 2) begin
            // long hold-off while requests keep coming
            stall_mode = 1;
            fork
               begin repeat (300) @(negedge clock); stall_mode = 0; end
            join_none
         end
         for (k = 0; k < 100; k++) begin
            int r;
            r = $urandom_range(0, 19);
            if (r < 9) op = OP_MARK;
            else if (r < 13) op = OP_SCAN;
            else if (r < 19) op = OP_PERIOD;
            else op = 2'd3;
            tick_now = tick_now + $urandom_range(0, 40);
            send_req(op, 5'($urandom), ($urandom_range(0, 3) == 0) ? 16'($urandom)
                     : 16'($urandom_range(0, 60)),
                     ($urandom_range(0, 15) == 0) ? $urandom : tick_now);
            req_gap();
         end
      end

      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
